// ===== src/mig_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mig_pkg
// Shared types, constants and fixed-point helpers for the matrix inverter.
// ----------------------------------------------------------------------------
package mig_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int IDX_W     = 3;
	localparam int SIZE_W    = 4;
	localparam int DIV_STEPS = DATA_W + FRAC_W;
	localparam int DIVC_W    = $clog2(DIV_STEPS);
	localparam int PROD_W    = 2 * DATA_W;
	localparam int TRUNC_W   = PROD_W - FRAC_W;
	localparam int DIFF_W    = TRUNC_W + 2;

	localparam logic signed [DATA_W-1:0] ONE_Q  = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] MAX_Q  = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] MIN_Q  = 32'sh8000_0000;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_PV_RD,
		ST_PV_CK,
		ST_SW_RA,
		ST_SW_RB,
		ST_SW_WA,
		ST_SW_WB,
		ST_NM_RD,
		ST_NM_LD,
		ST_NM_DW,
		ST_NM_DV,
		ST_EL_CR,
		ST_EL_CC,
		ST_EL_RI,
		ST_EL_RJ,
		ST_EL_MW,
		ST_EL_SW,
		ST_EL_SV,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} state_t;

	// x - trunc(prod / 2^16), saturated to 32 bits
	function automatic logic signed [DATA_W-1:0] mul_sub(
		input logic signed [DATA_W-1:0] x,
		input logic signed [PROD_W-1:0] prod
	);
		logic signed [TRUNC_W-1:0] t;
		logic signed [DIFF_W-1:0]  d;
		t = TRUNC_W'(prod >>> FRAC_W);
		if (prod[PROD_W-1] && (prod[FRAC_W-1:0] != '0)) begin
			t = t + TRUNC_W'(1);
		end
		d = DIFF_W'(x) - DIFF_W'(t);
		if (d > DIFF_W'(MAX_Q)) begin
			mul_sub = MAX_Q;
		end else if (d < DIFF_W'(MIN_Q)) begin
			mul_sub = MIN_Q;
		end else begin
			mul_sub = d[DATA_W-1:0];
		end
	endfunction

endpackage

// ===== src/mig_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mig_div
// Radix-2 restoring divider: (num * 2^16) / den, truncated toward zero and
// saturated to 32 bits. One quotient bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module mig_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [mig_pkg::DATA_W-1:0] num,
	input  logic signed [mig_pkg::DATA_W-1:0] den,
	output logic                              done,
	output logic signed [mig_pkg::DATA_W-1:0] quo
);
	import mig_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic                    sign_q;
	logic [DIVC_W-1:0]       cnt_q;
	logic [DIV_STEPS-1:0]    dvd_q;
	logic [DATA_W-1:0]       den_q;
	logic [DATA_W-1:0]       rem_q;
	logic [DATA_W:0]         trial;
	logic [DATA_W:0]         diff;
	logic                    ge;
	logic [DATA_W-1:0]       num_abs;
	logic [DATA_W-1:0]       den_abs;

	assign num_abs = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
	assign den_abs = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
	assign trial   = {rem_q, dvd_q[DIV_STEPS-1]};
	assign diff    = trial - {1'b0, den_q};
	assign ge      = ~diff[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIVC_W'(1);
			if (cnt_q == DIVC_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sign_q <= num[DATA_W-1] ^ den[DATA_W-1];
			dvd_q  <= {num_abs, {FRAC_W{1'b0}}};
			den_q  <= den_abs;
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			dvd_q <= {dvd_q[DIV_STEPS-2:0], ge};
		end
	end

	always_comb begin
		if (!sign_q) begin
			quo = (dvd_q > DIV_STEPS'(MAX_Q)) ? MAX_Q : dvd_q[DATA_W-1:0];
		end else begin
			quo = (dvd_q > DIV_STEPS'({1'b1, {(DATA_W-1){1'b0}}})) ?
				MIN_Q : DATA_W'(-dvd_q[DATA_W-1:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== src/matrix_inverse_gauss_jordan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan_core
// Gauss-Jordan inverter for an N x N signed Q16.16 matrix (N <= MAX_SIZE).
// ----------------------------------------------------------------------------
// Usage:
//   Write N to cfg_wr_data with cfg_wr_en while the block is idle; a write
//   drops any partly loaded matrix. Then send N*N elements row-major on the
//   s_ stream, one item per cycle while s_tready is high.
//   After the last element s_tready drops while the block eliminates in
//   place in two block memories. Each normalize step runs the shared
//   bit-serial divider; each elimination step uses one 32x32 multiplier
//   twice. Compute time is dominated by the divider. The N*N results then
//   leave row-major on the m_ stream; each is read from memory, loaded into
//   the output register and held until taken before the next is read, with
//   tlast on the final one and tuser set (value zero) when no pivot could be
//   found. A stalled receiver simply holds the output register; nothing is
//   lost. s_tready returns once tlast is taken.
//   Reset sets N to 8 and empties the load counter; memory contents are
//   not cleared and need not be.
// ----------------------------------------------------------------------------
module matrix_inverse_gauss_jordan_core #(
	parameter int MAX_SIZE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mig_pkg::SIZE_W-1:0]        cfg_wr_data,   // matrix_size
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,       // element_value
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] inverse_value, [34:32] row_index, [37:35] column_index, zero pad
	output logic [39:0]                       m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser        // singular
);
	import mig_pkg::*;

	localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);

	state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] n;
	logic [IDX_W-1:0]  nm1;

	logic [IDX_W-1:0] ld_r_q, ld_c_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             sing_q;

	logic signed [DATA_W-1:0] w_mem [DEPTH];
	logic signed [DATA_W-1:0] v_mem [DEPTH];
	logic signed [DATA_W-1:0] rd_w_q, rd_v_q;

	logic signed [DATA_W-1:0] pivot_q, coef_q;
	logic signed [DATA_W-1:0] yw_q, yv_q, xw_q, xv_q, tw_q, tv_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [IDX_W-1:0]         a_row, a_col;
	logic [ADDR_W-1:0]        addr;
	logic                     w_we, v_we;
	logic signed [DATA_W-1:0] w_wd, v_wd;
	logic                     div_start, div_done;
	logic signed [DATA_W-1:0] div_num, div_quo;

	logic signed [DATA_W-1:0] out_val_q;
	logic [IDX_W-1:0]         out_row_q, out_col_q;
	logic                     out_last_q, out_sing_q, m_valid_q;

	logic s_acc, last_k, last_j, last_i, ld_last;

	always_comb begin
		if (size_q == '0) begin
			n = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			n = SIZE_W'(MAX_SIZE);
		end else begin
			n = size_q;
		end
	end
	assign nm1 = IDX_W'(n - SIZE_W'(1));

	assign s_acc   = s_tvalid && s_tready;
	assign last_k  = (k_q == nm1);
	assign last_j  = (j_q == nm1);
	assign last_i  = (i_q == nm1);
	assign ld_last = (ld_r_q == nm1) && (ld_c_q == nm1);

	mig_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (pivot_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:   if (s_acc && ld_last) state_d = ST_PV_RD;
			ST_PV_RD:  state_d = ST_PV_CK;
			ST_PV_CK: begin
				if (rd_w_q != '0) begin
					state_d = (j_q == i_q) ? ST_NM_RD : ST_SW_RA;
				end else if (last_j) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_PV_RD;
				end
			end
			ST_SW_RA:  state_d = ST_SW_RB;
			ST_SW_RB:  state_d = ST_SW_WA;
			ST_SW_WA:  state_d = ST_SW_WB;
			ST_SW_WB:  state_d = last_k ? ST_NM_RD : ST_SW_RA;
			ST_NM_RD:  state_d = ST_NM_LD;
			ST_NM_LD:  state_d = ST_NM_DW;
			ST_NM_DW:  if (div_done) state_d = ST_NM_DV;
			ST_NM_DV: begin
				if (div_done) state_d = last_k ? ST_EL_CR : ST_NM_RD;
			end
			ST_EL_CR: begin
				if (j_q != i_q) begin
					state_d = ST_EL_CC;
				end else if (last_j) begin
					state_d = last_i ? ST_OUT_RD : ST_PV_RD;
				end
			end
			ST_EL_CC:  state_d = ST_EL_RI;
			ST_EL_RI:  state_d = ST_EL_RJ;
			ST_EL_RJ:  state_d = ST_EL_MW;
			ST_EL_MW:  state_d = ST_EL_SW;
			ST_EL_SW:  state_d = ST_EL_SV;
			ST_EL_SV: begin
				if (!last_k) begin
					state_d = ST_EL_RI;
				end else if (!last_j) begin
					state_d = ST_EL_CR;
				end else begin
					state_d = last_i ? ST_OUT_RD : ST_PV_RD;
				end
			end
			ST_OUT_RD:   state_d = ST_OUT_LD;
			ST_OUT_LD:   state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				if (m_tready) state_d = out_last_q ? ST_LOAD : ST_OUT_RD;
			end
			default:     state_d = ST_LOAD;
		endcase
	end

	// memory port, divider and handshake controls
	always_comb begin
		a_row     = i_q;
		a_col     = k_q;
		w_we      = 1'b0;
		v_we      = 1'b0;
		w_wd      = rd_w_q;
		v_wd      = rd_v_q;
		div_start = 1'b0;
		div_num   = rd_w_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				a_row    = ld_r_q;
				a_col    = ld_c_q;
				w_we     = s_acc;
				v_we     = s_acc;
				w_wd     = s_tdata;
				v_wd     = (ld_r_q == ld_c_q) ? ONE_Q : '0;
			end
			ST_PV_RD: begin
				a_row = j_q;
				a_col = i_q;
			end
			ST_SW_RB: a_row = j_q;
			ST_SW_WA: begin
				w_we = 1'b1;
				v_we = 1'b1;
			end
			ST_SW_WB: begin
				a_row = j_q;
				w_we  = 1'b1;
				v_we  = 1'b1;
				w_wd  = tw_q;
				v_wd  = tv_q;
			end
			ST_NM_LD: div_start = 1'b1;
			ST_NM_DW: begin
				w_we      = div_done;
				w_wd      = div_quo;
				div_start = div_done;
				div_num   = yv_q;
			end
			ST_NM_DV: begin
				v_we = div_done;
				v_wd = div_quo;
			end
			ST_EL_CR: begin
				a_row = j_q;
				a_col = i_q;
			end
			ST_EL_RJ: a_row = j_q;
			ST_EL_SW: begin
				a_row = j_q;
				w_we  = 1'b1;
				w_wd  = mul_sub(xw_q, prod_q);
			end
			ST_EL_SV: begin
				a_row = j_q;
				v_we  = 1'b1;
				v_wd  = mul_sub(xv_q, prod_q);
			end
			ST_OUT_RD: begin
				a_row = j_q;
			end
			default: ;
		endcase
	end

	assign addr = ADDR_W'(a_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(a_col);

	always_ff @(posedge clk) begin
		if (w_we) w_mem[addr] <= w_wd;
		if (v_we) v_mem[addr] <= v_wd;
		rd_w_q <= w_mem[addr];
		rd_v_q <= v_mem[addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_PV_CK) pivot_q <= rd_w_q;
		if (state_q == ST_SW_RB) begin
			tw_q <= rd_w_q;
			tv_q <= rd_v_q;
		end
		if (state_q == ST_NM_LD) yv_q <= rd_v_q;
		if (state_q == ST_EL_CC) coef_q <= rd_w_q;
		if (state_q == ST_EL_RJ) begin
			yw_q <= rd_w_q;
			yv_q <= rd_v_q;
		end
		if (state_q == ST_EL_MW) begin
			xw_q   <= rd_w_q;
			xv_q   <= rd_v_q;
			prod_q <= coef_q * yw_q;
		end
		if (state_q == ST_EL_SW) prod_q <= coef_q * yv_q;
		if (state_q == ST_OUT_LD) begin
			out_val_q  <= sing_q ? '0 : rd_v_q;
			out_row_q  <= j_q;
			out_col_q  <= k_q;
			out_last_q <= last_j && last_k;
			out_sing_q <= sing_q;
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			size_q    <= SIZE_W'(8);
			ld_r_q    <= '0;
			ld_c_q    <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			sing_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
				ld_r_q <= '0;
				ld_c_q <= '0;
			end else if (s_acc) begin
				if (ld_c_q == nm1) begin
					ld_c_q <= '0;
					ld_r_q <= (ld_r_q == nm1) ? '0 : ld_r_q + IDX_W'(1);
				end else begin
					ld_c_q <= ld_c_q + IDX_W'(1);
				end
			end
			case (state_q)
				ST_LOAD: begin
					if (s_acc && ld_last) begin
						sing_q <= 1'b0;
						i_q    <= '0;
						j_q    <= '0;
					end
				end
				ST_PV_CK: begin
					k_q <= '0;
					if (rd_w_q == '0) begin
						if (last_j) begin
							sing_q <= 1'b1;
							j_q    <= '0;
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				ST_SW_WB: k_q <= last_k ? '0 : k_q + IDX_W'(1);
				ST_NM_DV: begin
					if (div_done) begin
						k_q <= last_k ? '0 : k_q + IDX_W'(1);
						if (last_k) j_q <= '0;
					end
				end
				ST_EL_CR: begin
					if (j_q == i_q) begin
						if (!last_j) begin
							j_q <= j_q + IDX_W'(1);
						end else if (last_i) begin
							j_q <= '0;
							k_q <= '0;
						end else begin
							i_q <= i_q + IDX_W'(1);
							j_q <= i_q + IDX_W'(1);
						end
					end
				end
				ST_EL_CC: k_q <= '0;
				ST_EL_SV: begin
					if (!last_k) begin
						k_q <= k_q + IDX_W'(1);
					end else if (!last_j) begin
						j_q <= j_q + IDX_W'(1);
					end else if (last_i) begin
						j_q <= '0;
						k_q <= '0;
					end else begin
						i_q <= i_q + IDX_W'(1);
						j_q <= i_q + IDX_W'(1);
					end
				end
				ST_OUT_LD: m_valid_q <= 1'b1;
				ST_OUT_HOLD: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (last_k) begin
							k_q <= '0;
							j_q <= last_j ? '0 : j_q + IDX_W'(1);
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_col_q, out_row_q, out_val_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_sing_q;

endmodule

// ===== dv/matrix_inverse_gauss_jordan_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan_core_test
// Self-checking bench for the Gauss-Jordan inverter. Matrices of random order
// and content are streamed in. A local fixed-point inverter predicts every
// output element, and each one is checked field by field. Sender gaps and
// receiver stalls vary by phase, and one long output hold-off backs up input.
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [31:0] value;
	logic [2:0]         row;
	logic [2:0]         col;
	logic               last;
	logic               sing;
} inv_elem_t;

class inverse_scoreboard;
	int unsigned        size_reg = 8;
	int unsigned        loaded   = 0;
	logic signed [31:0] mat [8][8];
	inv_elem_t          pending [$];
	int                 errors    = 0;
	int                 checked   = 0;
	int                 inversions = 0;
	int                 singulars = 0;

	function int unsigned order();
		if (size_reg == 0) return 1;
		if (size_reg > 8) return 8;
		return size_reg;
	endfunction

	function void set_size(int unsigned v);
		size_reg = v;
		loaded   = 0;
	endfunction

	function logic signed [31:0] sat(longint v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function void invert(int unsigned n);
		logic signed [31:0] w [8][8];
		logic signed [31:0] v [8][8];
		logic signed [31:0] t;
		longint             pivot, coef;
		bit                 sing;
		inv_elem_t          e;
		int                 swap_row;
		w    = mat;
		sing = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				v[i][j] = (i == j) ? 32'sh0001_0000 : 32'sh0;
		for (int i = 0; i < n && !sing; i++) begin
			if (w[i][i] == 0) begin
				// only rows below the pivot row are searched
				swap_row = -1;
				for (int j = i + 1; j < n; j++)
					if (swap_row < 0 && w[j][i] != 0) swap_row = j;
				if (swap_row >= 0) begin
					for (int k = 0; k < n; k++) begin
						t = w[i][k]; w[i][k] = w[swap_row][k]; w[swap_row][k] = t;
						t = v[i][k]; v[i][k] = v[swap_row][k]; v[swap_row][k] = t;
					end
				end
			end
			pivot = w[i][i];
			if (pivot == 0) begin
				sing = 1;
			end else begin
				for (int k = 0; k < n; k++) begin
					w[i][k] = sat((longint'(w[i][k]) * 65536) / pivot);
					v[i][k] = sat((longint'(v[i][k]) * 65536) / pivot);
				end
				for (int j = 0; j < n; j++) begin
					if (j != i) begin
						coef = w[j][i];
						for (int k = 0; k < n; k++) begin
							w[j][k] = sat(longint'(w[j][k]) - (coef * w[i][k]) / 65536);
							v[j][k] = sat(longint'(v[j][k]) - (coef * v[i][k]) / 65536);
						end
					end
				end
			end
		end
		inversions++;
		if (sing) singulars++;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				e.value = sing ? 32'sh0 : v[r][c];
				e.row   = 3'(r);
				e.col   = 3'(c);
				e.last  = (r == n - 1 && c == n - 1);
				e.sing  = sing;
				pending.push_back(e);
			end
	endfunction

	function void note_element(logic signed [31:0] val);
		int unsigned n;
		n = order();
		if (loaded >= n * n) loaded = 0;
		mat[loaded / n][loaded % n] = val;
		loaded++;
		if (loaded == n * n) begin
			loaded = 0;
			invert(n);
		end
	endfunction

	function void check_result(logic [39:0] data, logic last, logic user);
		inv_elem_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result item: data=%h last=%b user=%b",
					data, last, user);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (data[31:0] !== e.value || data[34:32] !== e.row || data[37:35] !== e.col ||
				last !== e.last || user !== e.sing) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch: exp val=%h r=%0d c=%0d last=%b sing=%b,",
					" got val=%h r=%0d c=%0d last=%b sing=%b"},
					e.value, e.row, e.col, e.last, e.sing,
					data[31:0], data[34:32], data[37:35], last, user);
		end
	endfunction
endclass

module matrix_inverse_gauss_jordan_core_test;
	localparam int LIMIT = 2000000;
	localparam int ITEMS = 480;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [3:0]  cfg_wr_data = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	inverse_scoreboard sb;
	int          send_gap_pct = 0;
	int          stall_pct = 0;
	int          hold_len = 0;
	int          hold_left = 0;
	int          sent = 0;
	int          cycles = 0;

	matrix_inverse_gauss_jordan_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAIL matrix_inverse_gauss_jordan_core");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast, m_tuser);
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_element(logic [31:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_element(v);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(logic [3:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_size(v);
	endtask

	function automatic logic [31:0] make_element(int kind, int r, int c);
		logic signed [31:0] x;
		case (kind)
			0: begin // well conditioned: small off-diagonal, heavy diagonal
				x = $signed($urandom_range(262143)) - 131072;
				if (r == c) x = x + 32'sh0004_0000;
			end
			1: x = $urandom;
			2: x = ($urandom_range(1)) ? 32'sh0 : ($signed($urandom_range(6)) - 3) <<< 16;
			default: x = (r == c) ? 32'sh0 : ($signed($urandom_range(8)) - 4) <<< 14;
		endcase
		return x;
	endfunction

	task automatic send_matrix(int n, int kind);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				send_element(make_element(kind, r, c));
	endtask

	initial begin
		int n, sel, mats;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// order 1: zero, one, extremes, tiny value that overflows
		write_size(4'd1);
		send_element(32'h0000_0000);
		send_element(32'h0001_0000);
		send_element(32'h7fff_ffff);
		send_element(32'h8000_0000);
		send_element(32'hffff_ffff);
		send_element(32'h0000_0001);
		// size zero acts as one
		write_size(4'd0);
		send_element(32'hfffe_0000);
		// order 2: zero pivot needing a row swap, then two singular cases
		write_size(4'd2);
		send_element(32'h0); send_element(32'h0001_0000);
		send_element(32'h0002_0000); send_element(32'h0);
		send_element(32'h0); send_element(32'h0);
		send_element(32'h0); send_element(32'h0001_0000);
		send_element(32'h0001_0000); send_element(32'h0002_0000);
		send_element(32'h0002_0000); send_element(32'h0004_0000);
		// oversize setting, then rewrite mid-load drops what was loaded
		write_size(4'd15);
		send_element(32'h1234_5678);
		send_element(32'h8765_4321);
		write_size(4'd2);
		send_element(32'h0003_0000); send_element(32'h0001_0000);
		send_element(32'h0001_0000); send_element(32'h0002_0000);

		mats = 0;
		while (sent < ITEMS) begin
			case ((sent * 4) / ITEMS)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 55; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 55; end
				default: begin send_gap_pct = 20; stall_pct = 20; end
			endcase
			sel = $urandom_range(99);
			if (sel < 60) n = $urandom_range(1, 3);
			else if (sel < 85) n = $urandom_range(4, 5);
			else if (sel < 93) n = $urandom_range(6, 7);
			else if (sel < 96) n = 0;
			else n = $urandom_range(8, 15);
			write_size(4'(n));
			if (n == 0) n = 1;
			if (n > 8) n = 8;
			if (mats == 3) begin
				// hold the output long enough that the next matrix backs up
				hold_len = 6000;
				send_matrix(n, 0);
				send_matrix(n, 0);
			end else if ($urandom_range(9) == 0) begin
				// broken load: a few elements, then a size rewrite drops them
				for (int k = 0; k < $urandom_range(1, n * n); k++)
					send_element($urandom);
				write_size(4'(n));
				send_matrix(n, $urandom_range(3));
			end else begin
				for (int k = $urandom_range(1, 3); k > 0; k--)
					send_matrix(n, ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 3));
			end
			mats++;
		end

		drain();
		repeat (100) @(posedge clk);
		$display("ran %0d input items, %0d inversions (%0d singular), %0d outputs checked",
			sent, sb.inversions, sb.singulars, sb.checked);
		$display("orders 1..8 incl. out-of-range settings, mid-load rewrites, gaps and stalls");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS matrix_inverse_gauss_jordan_core");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
			$display("FAIL matrix_inverse_gauss_jordan_core");
		end
		$finish;
	end
endmodule

// ===== files.f =====
src/mig_pkg.sv
src/mig_div.sv
src/matrix_inverse_gauss_jordan_core.sv
dv/matrix_inverse_gauss_jordan_core_test.sv
